// ===== src/ekrt_pkg.sv =====
// ============================================================================
// ekrt_pkg
// Shared types and constants for the expiring key ring table: record layout,
// operation codes, field widths and reset values.
// ============================================================================
package ekrt_pkg;

    // Field widths
    localparam int OPC_W   = 2;
    localparam int GRP_W   = 16;
    localparam int SLOT_W  = 8;
    localparam int DELTA_W = 16;
    localparam int TIME_W  = 32;

    // Default table depth and expiry register reset value (300 s in ms)
    localparam int                TABLE_DEPTH_DEF = 256;
    localparam logic [TIME_W-1:0] EXPIRY_RESET_MS = 32'd300000;

    // Operation codes
    localparam logic [OPC_W-1:0] OP_TICK   = 2'd0;
    localparam logic [OPC_W-1:0] OP_QUERY  = 2'd1;
    localparam logic [OPC_W-1:0] OP_INSERT = 2'd2;
    localparam logic [OPC_W-1:0] OP_CLEAR  = 2'd3;

    // One stored record
    typedef struct packed {
        logic [GRP_W-1:0]  grp;
        logic [SLOT_W-1:0] slot;
        logic [TIME_W-1:0] stamp;
        logic              vld;
    } t_rec;

endpackage

// ===== src/expiring_key_ring_table_top.sv =====
// ============================================================================
// expiring_key_ring_table_top
// Ring of key records with a saturating millisecond clock. Query scans the
// record memory for the first valid key match and retires it if its age has
// reached the expiry limit; insert adds the key at the ring pointer when absent.
// ============================================================================
//
//  channel   | ports                                           | handshake
//  ----------+-------------------------------------------------+--------------------
//  command   | i_opcode i_group_index i_slot_index i_delta_ms  | start high, busy low
//  result    | o_present o_inserted                            | o_result_valid pulse
//  config    | i_expiry_ms                                     | i_expiry_we
//
//  Tick: result in the cycle after acceptance, busy stays low.
//  Query: scans the records in order until the first match or the last record;
//  insert then writes its record when the key is absent or expired. The scan reads
//  one record per cycle from the registered read port. Clear: one entry per cycle.
//  After reset the same sweep runs with busy high and no result. Results cannot
//  be stalled; each is shown for one cycle only.
//
module expiring_key_ring_table_top #(
    parameter int TABLE_DEPTH = ekrt_pkg::TABLE_DEPTH_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [ekrt_pkg::OPC_W-1:0]   i_opcode,
    input  logic [ekrt_pkg::GRP_W-1:0]   i_group_index,
    input  logic [ekrt_pkg::SLOT_W-1:0]  i_slot_index,
    input  logic [ekrt_pkg::DELTA_W-1:0] i_delta_ms,
    input  logic                        i_expiry_we,
    input  logic [ekrt_pkg::TIME_W-1:0]  i_expiry_ms,
    output logic                        o_result_valid,
    output logic                        o_present,
    output logic                        o_inserted
);
    import ekrt_pkg::*;

    localparam int             AW   = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam logic [AW-1:0]  LAST = AW'(TABLE_DEPTH - 1);

    // Controller states
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_INS  = 2'd2;
    localparam logic [1:0] ST_CLR  = 2'd3;

    // Record memory
    t_rec r_mem [TABLE_DEPTH];
    t_rec r_rd_data;

    // Control registers
    logic [1:0]        r_state, n_state;
    logic [AW-1:0]     r_addr, n_addr;
    logic              r_issue_done, n_issue_done;
    logic              r_rd_vld, n_rd_vld;
    logic [AW-1:0]     r_rd_addr, n_rd_addr;
    logic [AW-1:0]     r_ptr, n_ptr;
    logic [TIME_W-1:0] r_clock, n_clock;
    logic [TIME_W-1:0] r_expiry;
    logic              r_report, n_report;
    logic              r_res_vld, n_res_vld;

    // Transaction payload registers
    logic [OPC_W-1:0]  r_op, n_op;
    logic [GRP_W-1:0]  r_grp, n_grp;
    logic [SLOT_W-1:0] r_slot, n_slot;
    logic [TIME_W-1:0] r_limit, n_limit;
    logic              r_lim_ok, n_lim_ok;
    logic              r_exp_zero, n_exp_zero;
    logic              r_present, n_present;
    logic              r_inserted, n_inserted;

    // Memory port controls
    logic              w_mem_we;
    logic [AW-1:0]     w_mem_waddr;
    t_rec              w_mem_wdata;
    logic              w_mem_re;

    logic              w_hit;
    logic              w_expired;
    logic              w_last;
    logic [TIME_W:0]   w_sum;
    logic [TIME_W:0]   w_diff;

    // Memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_mem[w_mem_waddr] <= w_mem_wdata;
        end
        if (w_mem_re) begin
            r_rd_data <= r_mem[r_addr];
        end
    end

    // Compare the record read last cycle; limit = clock - expiry fixed per query
    assign w_hit     = r_rd_vld && r_rd_data.vld &&
                       (r_rd_data.grp == r_grp) && (r_rd_data.slot == r_slot);
    assign w_expired = r_exp_zero || (r_lim_ok && (r_rd_data.stamp <= r_limit));
    assign w_last    = (r_rd_addr == LAST);
    assign w_sum     = {1'b0, r_clock} + {{(TIME_W + 1 - DELTA_W){1'b0}}, i_delta_ms};
    assign w_diff    = {1'b0, r_clock} - {1'b0, r_expiry};

    // Next-state logic
    always_comb begin
        n_state      = r_state;
        n_addr       = r_addr;
        n_issue_done = r_issue_done;
        n_rd_vld     = 1'b0;
        n_rd_addr    = r_rd_addr;
        n_ptr        = r_ptr;
        n_clock      = r_clock;
        n_report     = r_report;
        n_res_vld    = 1'b0;
        n_op         = r_op;
        n_grp        = r_grp;
        n_slot       = r_slot;
        n_limit      = r_limit;
        n_lim_ok     = r_lim_ok;
        n_exp_zero   = r_exp_zero;
        n_present    = 1'b0;
        n_inserted   = 1'b0;
        w_mem_we     = 1'b0;
        w_mem_waddr  = r_rd_addr;
        w_mem_wdata  = '0;
        w_mem_re     = 1'b0;

        unique case (r_state)
            ST_IDLE: begin
                if (start) begin
                    unique case (i_opcode)
                        OP_TICK: begin
                            // Advance the clock, saturate at all ones
                            n_clock   = w_sum[TIME_W] ? '1 : w_sum[TIME_W-1:0];
                            n_res_vld = 1'b1;
                        end
                        OP_QUERY, OP_INSERT: begin
                            n_op         = i_opcode;
                            n_grp        = i_group_index;
                            n_slot       = i_slot_index;
                            n_limit      = w_diff[TIME_W-1:0];
                            n_lim_ok     = !w_diff[TIME_W];
                            n_exp_zero   = (r_expiry == '0);
                            n_addr       = '0;
                            n_issue_done = 1'b0;
                            n_state      = ST_SCAN;
                        end
                        OP_CLEAR: begin
                            n_addr   = '0;
                            n_ptr    = '0;
                            n_clock  = '0;
                            n_report = 1'b1;
                            n_state  = ST_CLR;
                        end
                        default: begin
                            n_state = ST_IDLE;
                        end
                    endcase
                end
            end

            ST_SCAN: begin
                // Issue one read per cycle
                if (!r_issue_done) begin
                    w_mem_re  = 1'b1;
                    n_rd_vld  = 1'b1;
                    n_rd_addr = r_addr;
                    if (r_addr == LAST) begin
                        n_issue_done = 1'b1;
                    end else begin
                        n_addr = r_addr + 1'b1;
                    end
                end
                // Stop at the first match or after the last record
                if (w_hit) begin
                    n_rd_vld = 1'b0;
                    if (w_expired) begin
                        w_mem_we        = 1'b1;
                        w_mem_waddr     = r_rd_addr;
                        w_mem_wdata     = r_rd_data;
                        w_mem_wdata.vld = 1'b0;
                        if (r_op == OP_INSERT) begin
                            n_state = ST_INS;
                        end else begin
                            n_state   = ST_IDLE;
                            n_res_vld = 1'b1;
                        end
                    end else begin
                        n_state   = ST_IDLE;
                        n_res_vld = 1'b1;
                        n_present = 1'b1;
                    end
                end else if (r_rd_vld && w_last) begin
                    n_rd_vld = 1'b0;
                    if (r_op == OP_INSERT) begin
                        n_state = ST_INS;
                    end else begin
                        n_state   = ST_IDLE;
                        n_res_vld = 1'b1;
                    end
                end
            end

            ST_INS: begin
                // Overwrite the oldest record and advance the ring pointer
                w_mem_we          = 1'b1;
                w_mem_waddr       = r_ptr;
                w_mem_wdata.grp   = r_grp;
                w_mem_wdata.slot  = r_slot;
                w_mem_wdata.stamp = r_clock;
                w_mem_wdata.vld   = 1'b1;
                n_ptr             = (r_ptr == LAST) ? '0 : r_ptr + 1'b1;
                n_res_vld         = 1'b1;
                n_inserted        = 1'b1;
                n_state           = ST_IDLE;
            end

            ST_CLR: begin
                // Sweep the memory, one entry per cycle
                w_mem_we    = 1'b1;
                w_mem_waddr = r_addr;
                w_mem_wdata = '0;
                if (r_addr == LAST) begin
                    n_state   = ST_IDLE;
                    n_res_vld = r_report;
                    n_report  = 1'b0;
                end else begin
                    n_addr = r_addr + 1'b1;
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_CLR;
            r_addr       <= '0;
            r_issue_done <= 1'b0;
            r_rd_vld     <= 1'b0;
            r_rd_addr    <= '0;
            r_ptr        <= '0;
            r_clock      <= '0;
            r_expiry     <= EXPIRY_RESET_MS;
            r_report     <= 1'b0;
            r_res_vld    <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_addr       <= n_addr;
            r_issue_done <= n_issue_done;
            r_rd_vld     <= n_rd_vld;
            r_rd_addr    <= n_rd_addr;
            r_ptr        <= n_ptr;
            r_clock      <= n_clock;
            r_report     <= n_report;
            r_res_vld    <= n_res_vld;
            if (i_expiry_we) begin
                r_expiry <= i_expiry_ms;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_op       <= n_op;
        r_grp      <= n_grp;
        r_slot     <= n_slot;
        r_limit    <= n_limit;
        r_lim_ok   <= n_lim_ok;
        r_exp_zero <= n_exp_zero;
        r_present  <= n_present;
        r_inserted <= n_inserted;
    end

    assign busy           = (r_state != ST_IDLE);
    assign o_result_valid = r_res_vld;
    assign o_present      = r_present;
    assign o_inserted     = r_inserted;

endmodule

// ===== src/ekrt_checker.sv =====
// ============================================================================
// ekrt_checker
// Port-level checks on the expiring key ring table: command acceptance,
// result timing and result field consistency.
// ============================================================================
module ekrt_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       start,
    input logic                       busy,
    input logic [ekrt_pkg::OPC_W-1:0] i_opcode,
    input logic                       o_result_valid,
    input logic                       o_present,
    input logic                       o_inserted
);
    import ekrt_pkg::*;

    // Every accepted transaction either finishes next cycle or holds busy
    a_accept_progress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (busy || o_result_valid))
        else $error("accepted transaction neither busy nor finished");

    // A tick finishes in the next cycle with both flags low
    a_tick_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_opcode == OP_TICK)
        |=> (o_result_valid && !o_present && !o_inserted))
        else $error("tick result missing or flagged");

    // A result is shown only once the block is idle again
    a_result_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> !busy)
        else $error("result while busy");

    // A written record means the key was absent
    a_insert_absent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && o_inserted) |-> !o_present)
        else $error("insert reported while key present");

endmodule

bind expiring_key_ring_table_top ekrt_checker u_ekrt_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .start          (start),
    .busy           (busy),
    .i_opcode       (i_opcode),
    .o_result_valid (o_result_valid),
    .o_present      (o_present),
    .o_inserted     (o_inserted)
);
